// ===== hdl/rbsd_pkg.sv =====
package rbsd_pkg;

	localparam int MAX_DIM_DEF = 1024;
	localparam int RES_CAP     = 64;

	// result kinds
	localparam logic [1:0] KIND_SPAN  = 2'd0;
	localparam logic [1:0] KIND_PIXEL = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_WIDTH    = 3'd0;
	localparam logic [2:0] CFG_HEIGHT   = 3'd1;
	localparam logic [2:0] CFG_CLIP_L   = 3'd2;
	localparam logic [2:0] CFG_CLIP_R   = 3'd3;
	localparam logic [2:0] CFG_CLIP_T   = 3'd4;
	localparam logic [2:0] CFG_CLIP_B   = 3'd5;
	localparam logic [2:0] CFG_MODE     = 3'd6;
	localparam logic [2:0] CFG_GALPHA   = 3'd7;

	// stream phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_ALPHA  = 2'd1;
	localparam logic [1:0] PH_COL_HI = 2'd2;
	localparam logic [1:0] PH_COL_LO = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_req;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  x_start;
		logic [9:0]  x_end;
		logic [9:0]  row;
		logic [15:0] color;
		logic [7:0]  alpha;
		logic        last;
		logic        done_res;
	} res_t;

	// one clipped segment of a run or one literal pixel
	typedef struct packed {
		logic        draw;
		logic        wrap;
		logic [9:0]  xs;
		logic [9:0]  xe;
		logic [12:0] left;
		logic [12:0] xi1c;
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RUN,
		ST_PIXEL,
		ST_FLUSH
	} state_t;

endpackage

// ===== hdl/rbsd_span_clip.sv =====
module rbsd_span_clip (
	input  logic [12:0]        xi,
	input  logic [12:0]        xi1,
	input  logic [10:0]        ew,
	input  logic signed [11:0] clip_left,
	input  logic signed [11:0] clip_right,
	input  logic               visible,
	output rbsd_pkg::seg_t     seg
);

	logic [12:0]        w13;
	logic               wrap;
	logic [12:0]        xi1c;
	logic signed [13:0] xi_s;
	logic signed [13:0] xe_cand;
	logic signed [13:0] cl_s;
	logic signed [13:0] cr_s;
	logic signed [13:0] xs_s;
	logic signed [13:0] xe_s;

	always_comb begin
		w13     = {2'b00, ew};
		wrap    = xi1 >= w13;
		xi1c    = wrap ? w13 : xi1;
		xi_s    = $signed({1'b0, xi});
		xe_cand = $signed({1'b0, xi1c}) - 14'sd1;
		cl_s    = {{2{clip_left[11]}}, clip_left};
		cr_s    = {{2{clip_right[11]}}, clip_right};
		xs_s    = (xi_s > cl_s) ? xi_s : cl_s;
		xe_s    = (xe_cand < cr_s) ? xe_cand : cr_s;

		seg.draw = visible && (xs_s <= xe_s);
		seg.wrap = wrap;
		seg.xs   = xs_s[9:0];
		seg.xe   = xe_s[9:0];
		seg.left = xi1 - w13;
		seg.xi1c = xi1c;
	end

endmodule

// ===== hdl/rle16_bitmap_span_decoder.sv =====
// channel | handshake             | payload
// item    | item_valid/item_ready | item  (data_byte, start_req)
// res     | res_valid/res_ready   | res   (kind .. done_res)
// cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
// a header, alpha or colour-high byte is accepted, decoded and then closed
// the colour-low byte adds a run step per row segment of a run, held while the result register is full,
// or a pixel step for a literal pixel, since a single span clip unit is stepped over the segments
// a byte that arrives after decoding has ended is accepted, passes the decode state only and gives no beat
// a full result register holds the sequencer; the next byte is taken once the last result
// has moved into the result register
// reset clears control state; there is no memory and no clearing pass
module rle16_bitmap_span_decoder #(
	parameter int MAX_DIM = rbsd_pkg::MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  rbsd_pkg::item_t       item,
	output logic                  res_valid,
	input  logic                  res_ready,
	output rbsd_pkg::res_t        res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [11:0]           cfg_data
);

	localparam logic [12:0] MAX_D = 13'(MAX_DIM);

	// configuration
	logic [10:0]        width_q;
	logic [10:0]        height_q;
	logic signed [11:0] clip_l_q;
	logic signed [11:0] clip_r_q;
	logic signed [11:0] clip_t_q;
	logic signed [11:0] clip_b_q;
	logic [1:0]         mode_q;
	logic [7:0]         galpha_q;

	// decoder state
	rbsd_pkg::state_t state_q, state_nx;
	logic [1:0]  phase_q;
	logic [6:0]  remaining_q;
	logic        is_run_q;
	logic [11:0] column_q;
	logic [11:0] line_q;
	logic [20:0] pixels_q;
	logic [7:0]  held_alpha_q;
	logic [7:0]  color_high_q;
	logic        finished_q;
	logic [7:0]  byte_q;

	logic [12:0] xi_q;
	logic [12:0] xi1_q;
	logic [15:0] color_q;
	logic [7:0]  alpha_q;
	logic [6:0]  cnt_q;
	logic [21:0] total_q;

	logic           pend_valid_q;
	rbsd_pkg::res_t pend_q;
	logic           res_valid_q;
	rbsd_pkg::res_t res_q;

	// derived values
	logic [10:0]        ew;
	logic [10:0]        eh;
	logic signed [13:0] eh_s;
	logic signed [13:0] cb1_s;
	logic signed [13:0] rl_s;
	logic signed [13:0] line_s;
	logic signed [13:0] ct_s;
	logic               visible;
	rbsd_pkg::seg_t     seg;

	logic        out_free;
	logic        new_res;
	logic        stall_run;
	logic        push_mid;
	logic        have_item;
	logic        push_fin;

	logic [20:0] ps_hdr;
	logic [12:0] col_inc;
	logic        col_wrap;
	logic [11:0] line_pix;
	logic [6:0]  rem_dec;
	logic [15:0] alpha_prod;

	always_comb begin
		if (width_q < 11'd2) begin
			ew = 11'd2;
		end else if ({2'b00, width_q} > MAX_D) begin
			ew = 11'(MAX_DIM);
		end else begin
			ew = width_q;
		end
		if (height_q < 11'd1) begin
			eh = 11'd1;
		end else if ({2'b00, height_q} > MAX_D) begin
			eh = 11'(MAX_DIM);
		end else begin
			eh = height_q;
		end
		eh_s    = $signed({3'b000, eh});
		cb1_s   = {{2{clip_b_q[11]}}, clip_b_q} + 14'sd1;
		rl_s    = (eh_s > cb1_s) ? cb1_s : eh_s;
		line_s  = $signed({2'b00, line_q});
		ct_s    = {{2{clip_t_q[11]}}, clip_t_q};
		visible = (line_s >= ct_s) && (line_s < rl_s);

		ps_hdr     = pixels_q + 21'(byte_q[6:0]);
		col_inc    = {1'b0, column_q} + 13'd1;
		col_wrap   = col_inc >= {2'b00, ew};
		line_pix   = col_wrap ? line_q + 12'd1 : line_q;
		rem_dec    = remaining_q - 7'd1;
		alpha_prod = held_alpha_q * galpha_q;
	end

	rbsd_span_clip u_clip (
		.xi         (xi_q),
		.xi1        (xi1_q),
		.ew         (ew),
		.clip_left  (clip_l_q),
		.clip_right (clip_r_q),
		.visible    (visible),
		.seg        (seg)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rbsd_pkg::ST_IDLE: begin
				if (item_valid) state_nx = rbsd_pkg::ST_EXEC;
			end
			rbsd_pkg::ST_EXEC: begin
				if (finished_q) begin
					state_nx = rbsd_pkg::ST_IDLE;
				end else if (phase_q == rbsd_pkg::PH_COL_LO) begin
					state_nx = is_run_q ? rbsd_pkg::ST_RUN : rbsd_pkg::ST_PIXEL;
				end else begin
					state_nx = rbsd_pkg::ST_FLUSH;
				end
			end
			rbsd_pkg::ST_RUN: begin
				if (!stall_run && !seg.wrap) state_nx = rbsd_pkg::ST_FLUSH;
			end
			rbsd_pkg::ST_PIXEL: begin
				state_nx = rbsd_pkg::ST_FLUSH;
			end
			rbsd_pkg::ST_FLUSH: begin
				if (!(have_item && !out_free)) state_nx = rbsd_pkg::ST_IDLE;
			end
			default: state_nx = rbsd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_ready = (state_q == rbsd_pkg::ST_IDLE);
		out_free   = !res_valid_q || res_ready;
		new_res    = ((state_q == rbsd_pkg::ST_RUN) || (state_q == rbsd_pkg::ST_PIXEL))
			&& seg.draw && (cnt_q < 7'(rbsd_pkg::RES_CAP));
		stall_run  = (state_q == rbsd_pkg::ST_RUN) && new_res && pend_valid_q && !out_free;
		push_mid   = (state_q == rbsd_pkg::ST_RUN) && new_res && pend_valid_q && out_free;
		have_item  = pend_valid_q || (finished_q && (cnt_q == 7'd0));
		push_fin   = (state_q == rbsd_pkg::ST_FLUSH) && have_item && out_free;
	end

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd2;
			height_q <= 11'd1;
			clip_l_q <= 12'sd0;
			clip_r_q <= 12'sd1023;
			clip_t_q <= 12'sd0;
			clip_b_q <= 12'sd1023;
			mode_q   <= 2'd0;
			galpha_q <= 8'd255;
		end else if (cfg_valid) begin
			case (cfg_index)
				rbsd_pkg::CFG_WIDTH:  width_q  <= cfg_data[10:0];
				rbsd_pkg::CFG_HEIGHT: height_q <= cfg_data[10:0];
				rbsd_pkg::CFG_CLIP_L: clip_l_q <= cfg_data;
				rbsd_pkg::CFG_CLIP_R: clip_r_q <= cfg_data;
				rbsd_pkg::CFG_CLIP_T: clip_t_q <= cfg_data;
				rbsd_pkg::CFG_CLIP_B: clip_b_q <= cfg_data;
				rbsd_pkg::CFG_MODE:   mode_q   <= cfg_data[1:0];
				rbsd_pkg::CFG_GALPHA: galpha_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// pixel count of the whole bitmap, refreshed every cycle
	always_ff @(posedge clk) begin
		total_q <= ew * eh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rbsd_pkg::ST_IDLE;
			phase_q      <= rbsd_pkg::PH_HEADER;
			remaining_q  <= 7'd0;
			is_run_q     <= 1'b0;
			column_q     <= 12'd0;
			line_q       <= 12'd0;
			pixels_q     <= 21'd0;
			held_alpha_q <= 8'd0;
			color_high_q <= 8'd0;
			finished_q   <= 1'b0;
			cnt_q        <= 7'd0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				rbsd_pkg::ST_IDLE: begin
					if (item_valid && item.start_req) begin
						phase_q      <= rbsd_pkg::PH_HEADER;
						remaining_q  <= 7'd0;
						is_run_q     <= 1'b0;
						column_q     <= 12'd0;
						line_q       <= 12'd0;
						pixels_q     <= 21'd0;
						held_alpha_q <= 8'd0;
						color_high_q <= 8'd0;
						finished_q   <= 1'b0;
					end
				end
				rbsd_pkg::ST_EXEC: begin
					cnt_q <= 7'd0;
					if (!finished_q) begin
						case (phase_q)
							rbsd_pkg::PH_HEADER: begin
								remaining_q <= byte_q[6:0];
								is_run_q    <= byte_q[7];
								pixels_q    <= ps_hdr;
								if (!byte_q[7] && (byte_q[6:0] == 7'd0)) begin
									phase_q    <= rbsd_pkg::PH_HEADER;
									finished_q <= ({1'b0, ps_hdr} >= total_q) || (line_s >= rl_s);
								end else begin
									phase_q <= mode_q[0] ? rbsd_pkg::PH_ALPHA
										: rbsd_pkg::PH_COL_HI;
								end
							end
							rbsd_pkg::PH_ALPHA: begin
								held_alpha_q <= byte_q;
								phase_q      <= rbsd_pkg::PH_COL_HI;
							end
							rbsd_pkg::PH_COL_HI: begin
								color_high_q <= byte_q;
								phase_q      <= rbsd_pkg::PH_COL_LO;
							end
							default: ;
						endcase
					end
				end
				rbsd_pkg::ST_RUN: begin
					if (!stall_run) begin
						if (new_res) begin
							pend_valid_q <= 1'b1;
							cnt_q        <= cnt_q + 7'd1;
						end
						if (seg.wrap) begin
							line_q <= line_q + 12'd1;
						end else begin
							column_q   <= seg.xi1c[11:0];
							phase_q    <= rbsd_pkg::PH_HEADER;
							finished_q <= ({1'b0, pixels_q} >= total_q) || (line_s >= rl_s);
						end
					end
				end
				rbsd_pkg::ST_PIXEL: begin
					if (new_res) begin
						pend_valid_q <= 1'b1;
						cnt_q        <= cnt_q + 7'd1;
					end
					column_q    <= col_wrap ? 12'd0 : col_inc[11:0];
					line_q      <= line_pix;
					remaining_q <= rem_dec;
					if ($signed({2'b00, line_pix}) >= rl_s) begin
						phase_q    <= rbsd_pkg::PH_HEADER;
						finished_q <= 1'b1;
					end else if (rem_dec == 7'd0) begin
						phase_q    <= rbsd_pkg::PH_HEADER;
						finished_q <= ({1'b0, pixels_q} >= total_q)
							|| ($signed({2'b00, line_pix}) >= rl_s);
					end else begin
						phase_q <= mode_q[0] ? rbsd_pkg::PH_ALPHA : rbsd_pkg::PH_COL_HI;
					end
				end
				rbsd_pkg::ST_FLUSH: begin
					if (push_fin) pend_valid_q <= 1'b0;
				end
				default: ;
			endcase

			if (push_mid || push_fin) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_q <= item.data_byte;
		end
		if (state_q == rbsd_pkg::ST_EXEC) begin
			color_q <= mode_q[1] ? 16'd0 : {color_high_q, byte_q};
			alpha_q <= mode_q[0] ? alpha_prod[15:8] : galpha_q;
			xi_q    <= {1'b0, column_q};
			xi1_q   <= is_run_q ? {1'b0, column_q} + 13'(remaining_q) : col_inc;
		end
		if ((state_q == rbsd_pkg::ST_RUN) && !stall_run && seg.wrap) begin
			xi_q  <= 13'd0;
			xi1_q <= seg.left;
		end
		if (new_res && !stall_run) begin
			pend_q.kind     <= (state_q == rbsd_pkg::ST_RUN) ? rbsd_pkg::KIND_SPAN
				: rbsd_pkg::KIND_PIXEL;
			pend_q.x_start  <= seg.xs;
			pend_q.x_end    <= seg.xe;
			pend_q.row      <= line_q[9:0];
			pend_q.color    <= color_q;
			pend_q.alpha    <= alpha_q;
			pend_q.last     <= 1'b0;
			pend_q.done_res <= 1'b0;
		end
		if (push_mid) begin
			res_q <= pend_q;
		end else if (push_fin) begin
			if (pend_valid_q) begin
				res_q          <= pend_q;
			end else begin
				res_q.kind     <= rbsd_pkg::KIND_END;
				res_q.x_start  <= 10'd0;
				res_q.x_end    <= 10'd0;
				res_q.row      <= 10'd0;
				res_q.color    <= 16'd0;
				res_q.alpha    <= 8'd0;
			end
			res_q.last     <= 1'b1;
			res_q.done_res <= finished_q;
		end
	end

	// the next byte is only taken with nothing left over from the previous one
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rbsd_pkg::ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left when idle");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'(rbsd_pkg::RES_CAP))
		else $error("result count beyond cap");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> res_q.last)
		else $error("done beat not marked last");

	a_end_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.kind == rbsd_pkg::KIND_END))
		|-> (res_q.done_res && (res_q.x_start == 10'd0) && (res_q.color == 16'd0)))
		else $error("end marker beat not blank");

	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(finished_q) |-> $past(item_valid && item_ready && item.start_req))
		else $error("finished cleared without restart");

endmodule
